FILE: hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque unit.
package bdq_pkg;

	localparam int DataW = 32;

	// Command codes
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_REAR   = 3'd3;
	localparam logic [2:0] CMD_REMOVE     = 3'd4;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_REAR,
		CELL_POP_FRONT,
		CELL_POP_REAR,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DataW-1:0] data;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/bdq_cell.sv
// One deque slot: holds a word and its valid bit, trades with its neighbors.
module bdq_cell
	import bdq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic signed [DataW-1:0] left_value,
	input  logic                    left_valid,
	input  logic signed [DataW-1:0] right_value,
	input  logic                    right_valid,
	input  logic                    found_in,
	output logic                    found_out,
	input  logic signed [DataW-1:0] rear_in,
	output logic signed [DataW-1:0] rear_out,
	output logic signed [DataW-1:0] value,
	output logic                    valid
);

	logic signed [DataW-1:0] value_q;
	logic                    valid_q;
	logic signed [DataW-1:0] value_d;
	logic                    valid_d;
	logic                    is_last;
	logic                    shift;

	assign value = value_q;
	assign valid = valid_q;

	// First-match chain: this cell and all later ones close the gap
	assign shift     = found_in | (valid_q & (value_q == ctl.data));
	assign found_out = shift;

	// Rear word collects from the one cell that ends the sequence
	assign is_last  = valid_q & ~right_valid;
	assign rear_out = rear_in | (is_last ? value_q : '0);

	// Next word and valid bit
	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		case (ctl.op)
			CELL_PUSH_FRONT: begin
				value_d = left_value;
				valid_d = left_valid;
			end
			CELL_PUSH_REAR: begin
				if (!valid_q && left_valid) begin
					value_d = ctl.data;
					valid_d = 1'b1;
				end
			end
			CELL_POP_FRONT: begin
				value_d = right_value;
				valid_d = right_valid;
			end
			CELL_POP_REAR: begin
				valid_d = right_valid;
			end
			CELL_REMOVE: begin
				if (shift) begin
					value_d = right_value;
					valid_d = right_valid;
				end
			end
			default: begin
				value_d = value_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

FILE: hw/rtl/bounded_deque_with_remove_value_unit.sv
// Bounded deque of signed 32-bit words with push/pop at both ends and remove-by-value.
// For every command a word is accepted at an edge where start is high
// (busy is never raised), the row of DEPTH cells shifts, loads or closes a gap at that
// same edge, and the result appears with done for the next cycle only; the receiver
// cannot stall it, and a new command may be accepted in that same cycle. The rate is
// set by the row of cells, each of which updates in parallel every cycle; remove-value
// resolves the first match through a one-bit chain running the length of the row.
// front_value and rear_value read zero when the deque is empty.
module bounded_deque_with_remove_value_unit
	import bdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              cmd,
	input  logic signed [DataW-1:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic signed [DataW-1:0] front_value,
	output logic signed [DataW-1:0] rear_value
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]         count_q;
	logic [CntW-1:0]         count_d;
	status_t                 status_q;
	status_t                 status_d;
	logic                    done_q;
	cell_ctl_t               ctl;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    found;

	logic signed [DataW-1:0] cell_value [DEPTH];
	logic                    cell_valid [DEPTH];
	logic                    found_chain [DEPTH+1];
	logic signed [DataW-1:0] rear_chain [DEPTH+1];

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign full   = (count_q == CntW'(DEPTH));
	assign empty  = (count_q == '0);
	assign found  = found_chain[DEPTH];

	// Command decode into the row operation; does not depend on the match chain
	always_comb begin
		ctl.data = value;
		ctl.op   = CELL_HOLD;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (!full) begin
					ctl.op = CELL_PUSH_FRONT;
				end
			end
			CMD_PUSH_REAR: begin
				if (!full) begin
					ctl.op = CELL_PUSH_REAR;
				end
			end
			CMD_POP_FRONT: begin
				if (!empty) begin
					ctl.op = CELL_POP_FRONT;
				end
			end
			CMD_POP_REAR: begin
				if (!empty) begin
					ctl.op = CELL_POP_REAR;
				end
			end
			CMD_REMOVE: begin
				ctl.op = CELL_REMOVE;
			end
			default: begin
				ctl.op = CELL_HOLD;
			end
		endcase
		if (!accept) begin
			ctl.op = CELL_HOLD;
		end
	end

	// Next count and status
	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					count_d = count_q - 1'b1;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
		if (!accept) begin
			count_d = count_q;
		end
	end

	// Row of cells; ends tied to the incoming word and to empty
	assign found_chain[0] = 1'b0;
	assign rear_chain[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DataW-1:0] lv;
		logic                    lvd;
		logic signed [DataW-1:0] rv;
		logic                    rvd;

		if (i == 0) begin : g_head
			assign lv  = value;
			assign lvd = 1'b1;
		end else begin : g_mid
			assign lv  = cell_value[i-1];
			assign lvd = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv  = '0;
			assign rvd = 1'b0;
		end else begin : g_body
			assign rv  = cell_value[i+1];
			assign rvd = cell_valid[i+1];
		end

		bdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_value  (lv),
			.left_valid  (lvd),
			.right_value (rv),
			.right_valid (rvd),
			.found_in    (found_chain[i]),
			.found_out   (found_chain[i+1]),
			.rear_in     (rear_chain[i]),
			.rear_out    (rear_chain[i+1]),
			.value       (cell_value[i]),
			.valid       (cell_valid[i])
		);
	end

	// Count, status and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// Result word reads the state left by the command
	assign done        = done_q;
	assign status      = status_q;
	assign count       = count_q;
	assign front_value = cell_valid[0] ? cell_value[0] : '0;
	assign rear_value  = rear_chain[DEPTH];

endmodule

FILE: dv/bounded_deque_with_remove_value_unit_tb.sv
// Self-checking testbench for the bounded deque unit: directed table, then random commands.
`timescale 1ns / 1ps

module bounded_deque_with_remove_value_unit_tb;
	import bdq_pkg::*;

	localparam int DEPTH     = 16;
	localparam int CntW      = $clog2(DEPTH + 1);
	localparam int RandItems = 750;
	localparam int IdlePct   = 26;

	// Codes the block treats as no-ops
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam logic signed [DataW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DataW-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		status_t                 st;
		logic [CntW-1:0]         cnt;
		logic signed [DataW-1:0] fr;
		logic signed [DataW-1:0] rr;
	} deque_word_t;

	typedef struct packed {
		logic [2:0]              c;
		logic signed [DataW-1:0] v;
		logic [7:0]              rep;
		logic                    typed;
		deque_word_t             ew;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [2:0]              cmd;
	logic signed [DataW-1:0] value;
	logic                    done;
	logic [1:0]              status;
	logic [CntW-1:0]         count;
	logic signed [DataW-1:0] front_value;
	logic signed [DataW-1:0] rear_value;

	// Side-band from the driver: typed-in expectation for the word on the bus
	logic        row_typed;
	deque_word_t row_exp;

	// Predictor state and expected words in flight
	logic signed [DataW-1:0] dq_vals [DEPTH];
	int                      dq_count;
	deque_word_t             word_q [$];

	int  err_cnt;
	int  n_ok, n_full, n_empty, n_notfound, peak_count;
	int  n_items;
	bit  idle_en;
	dir_row_t dir_q [$];

	bounded_deque_with_remove_value_unit #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.done(done),
		.status(status),
		.count(count),
		.front_value(front_value),
		.rear_value(rear_value)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#800000;
		$display("bounded_deque_with_remove_value_unit_tb: FAIL");
		$finish;
	end

	// Apply one command to the predicted deque and return the word it should produce
	function automatic deque_word_t predict_deque(input logic [2:0] c,
			input logic signed [DataW-1:0] v);
		deque_word_t r;
		status_t     st;
		bit          found;
		int          pos;
		st    = ST_OK;
		found = 1'b0;
		pos   = 0;
		case (c)
			CMD_PUSH_FRONT: begin
				if (dq_count >= DEPTH) st = ST_FULL;
				else begin
					for (int i = dq_count; i > 0; i--) dq_vals[i] = dq_vals[i-1];
					dq_vals[0] = v;
					dq_count++;
				end
			end
			CMD_PUSH_REAR: begin
				if (dq_count >= DEPTH) st = ST_FULL;
				else begin
					dq_vals[dq_count] = v;
					dq_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (dq_count == 0) st = ST_EMPTY;
				else begin
					for (int i = 0; i + 1 < dq_count; i++) dq_vals[i] = dq_vals[i+1];
					dq_count--;
				end
			end
			CMD_POP_REAR: begin
				if (dq_count == 0) st = ST_EMPTY;
				else dq_count--;
			end
			CMD_REMOVE: begin
				// first match from the front
				for (int i = 0; i < dq_count; i++) begin
					if (!found && dq_vals[i] == v) begin
						found = 1'b1;
						pos   = i;
					end
				end
				if (!found) st = ST_NOTFOUND;
				else begin
					for (int i = pos; i + 1 < dq_count; i++) dq_vals[i] = dq_vals[i+1];
					dq_count--;
				end
			end
			default: ;
		endcase
		r.st  = st;
		r.cnt = dq_count[CntW-1:0];
		r.fr  = (dq_count > 0) ? dq_vals[0] : '0;
		r.rr  = (dq_count > 0) ? dq_vals[dq_count-1] : '0;
		return r;
	endfunction

	function automatic void flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// Monitor: check a finished word, then record the one accepted at this edge
	always @(posedge clk) begin
		deque_word_t act, ew, pw;
		if (arst_n) begin
			if (done) begin
				act = '{status_t'(status), count, front_value, rear_value};
				if (word_q.size() == 0) begin
					flag_error("result word with nothing expected");
				end else begin
					ew = word_q.pop_front();
					if (act.st !== ew.st || act.cnt !== ew.cnt ||
							act.fr !== ew.fr || act.rr !== ew.rr)
						flag_error($sformatf(
							"exp st=%0d cnt=%0d fr=%0d rr=%0d, got st=%0d cnt=%0d fr=%0d rr=%0d",
							ew.st, ew.cnt, ew.fr, ew.rr,
							act.st, act.cnt, act.fr, act.rr));
				end
				case (act.st)
					ST_OK:       n_ok++;
					ST_FULL:     n_full++;
					ST_EMPTY:    n_empty++;
					ST_NOTFOUND: n_notfound++;
					default: ;
				endcase
				if (int'(act.cnt) > peak_count) peak_count = act.cnt;
			end
			if (start && !busy) begin
				pw = predict_deque(cmd, value);
				word_q.push_back(row_typed ? row_exp : pw);
			end
		end
	end

	// Drive one command word and hold it until accepted
	task automatic send_word(input logic [2:0] c, input logic signed [DataW-1:0] v,
			input logic typed, input deque_word_t ew);
		while (idle_en && $urandom_range(99) < IdlePct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		value     <= v;
		row_typed <= typed;
		row_exp   <= ew;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic add_row(input logic [2:0] c, input logic signed [DataW-1:0] v,
			input int rep, input logic typed, input status_t st, input int cnt,
			input logic signed [DataW-1:0] fr, input logic signed [DataW-1:0] rr);
		dir_row_t row;
		row.c     = c;
		row.v     = v;
		row.rep   = rep[7:0];
		row.typed = typed;
		row.ew    = '{st, cnt[CntW-1:0], fr, rr};
		dir_q.push_back(row);
	endtask

	// Mostly extremes and small values so removes find duplicates
	function automatic logic signed [DataW-1:0] rand_value();
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return -32'sd1;
			4, 5, 6: return $signed(32'($urandom_range(7))) - 32'sd4;
			default: return $signed($urandom);
		endcase
	endfunction

	// Stimulus
	initial begin
		logic [2:0]              c;
		logic signed [DataW-1:0] v;
		int                      r;
		bit                      fill_phase;
		int                      guard;
		bit                      held_mid, held_late;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		cmd        <= CMD_PUSH_FRONT;
		value      <= '0;
		row_typed  <= 1'b0;
		row_exp    <= '0;
		dq_count   = 0;
		err_cnt    = 0;
		n_ok       = 0;
		n_full     = 0;
		n_empty    = 0;
		n_notfound = 0;
		peak_count = 0;
		n_items    = 0;
		idle_en    = 1'b1;
		held_mid   = 1'b0;
		held_late  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty refusals, no-ops, extremes, removal, fill to full
		add_row(CMD_POP_FRONT,  32'sd0,   1, 1'b1, ST_EMPTY,    0, 0, 0);
		add_row(CMD_POP_REAR,   -32'sd1,  1, 1'b1, ST_EMPTY,    0, 0, 0);
		add_row(CMD_REMOVE,     32'sd0,   1, 1'b1, ST_NOTFOUND, 0, 0, 0);
		add_row(CMD_RSVD7,      VAL_MAX,  1, 1'b1, ST_OK,       0, 0, 0);
		add_row(CMD_PUSH_FRONT, VAL_MAX,  1, 1'b1, ST_OK,       1, VAL_MAX, VAL_MAX);
		add_row(CMD_PUSH_REAR,  VAL_MIN,  1, 1'b1, ST_OK,       2, VAL_MAX, VAL_MIN);
		add_row(CMD_PUSH_FRONT, -32'sd1,  1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_REMOVE,     VAL_MAX,  1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_REMOVE,     32'sd12345, 1, 1'b0, ST_OK,     0, 0, 0);
		add_row(CMD_RSVD5,      32'sd7,   1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_POP_FRONT,  VAL_MIN,  1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_POP_REAR,   VAL_MAX,  1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_PUSH_REAR,  32'shAAAA_AAAA, DEPTH - 1, 1'b0, ST_OK, 0, 0, 0);
		add_row(CMD_PUSH_FRONT, 32'sh5555_5555, 1, 1'b0, ST_OK, 0, 0, 0);
		add_row(CMD_PUSH_REAR,  32'sd0,   1, 1'b1, ST_FULL, DEPTH,
			32'sh5555_5555, 32'shAAAA_AAAA);
		add_row(CMD_PUSH_FRONT, VAL_MIN,  1, 1'b0, ST_OK,       0, 0, 0);
		add_row(CMD_REMOVE,     32'shAAAA_AAAA, 1, 1'b0, ST_OK, 0, 0, 0);
		add_row(CMD_RSVD6,      32'sd0,   1, 1'b0, ST_OK,       0, 0, 0);

		foreach (dir_q[i]) begin
			for (int k = 0; k < int'(dir_q[i].rep); k++)
				send_word(dir_q[i].c, dir_q[i].v, dir_q[i].typed, dir_q[i].ew);
		end

		// Random: alternating fill and drain phases so both ends get hit often
		fill_phase = 1'b1;
		while (n_items < RandItems) begin
			if (n_items % 45 == 0) fill_phase = (n_items / 45) % 2 == 0;
			// quiet stretch with back-to-back words
			idle_en = !(n_items >= 350 && n_items < 500);
			// hold off until the block has drained
			if ((n_items == 250 && !held_mid) || (n_items == 600 && !held_late)) begin
				if (n_items == 250) held_mid = 1'b1;
				else held_late = 1'b1;
				start <= 1'b0;
				@(posedge clk);
				while (word_q.size() != 0) @(posedge clk);
			end
			r = $urandom_range(99);
			if (r < 4) begin
				c = CMD_RSVD5 + 3'($urandom_range(2));
			end else if (fill_phase) begin
				if (r < 69) c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
				else if (r < 84) c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
				else c = CMD_REMOVE;
			end else begin
				if (r < 19) c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
				else if (r < 79) c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
				else c = CMD_REMOVE;
			end
			if (c == CMD_REMOVE && dq_count > 0 && $urandom_range(99) < 65)
				v = dq_vals[$urandom_range(dq_count - 1)];
			else
				v = rand_value();
			send_word(c, v, 1'b0, '0);
			if (c <= CMD_REMOVE) n_items++;
		end

		// Drain
		start <= 1'b0;
		guard = 0;
		while (word_q.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (word_q.size() != 0) flag_error("expected words never arrived");

		$display("Covered %0d random commands after the directed table; peak count %0d of %0d.",
			n_items, peak_count, DEPTH);
		$display("Status seen: ok %0d, full %0d, empty %0d, not found %0d; errors %0d.",
			n_ok, n_full, n_empty, n_notfound, err_cnt);
		if (err_cnt == 0) begin
			$display("bounded_deque_with_remove_value_unit_tb: PASS");
		end else begin
			$display("bounded_deque_with_remove_value_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: bounded_deque_with_remove_value_unit.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_deque_with_remove_value_unit.sv
dv/bounded_deque_with_remove_value_unit_tb.sv
